FILE: design/i2c_slave_mailbox_fifo_bridge_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef I2C_SLAVE_MAILBOX_FIFO_BRIDGE_UNIT_MACROS_SVH
`define I2C_SLAVE_MAILBOX_FIFO_BRIDGE_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ISMB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ISMB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/ismb_pkg.sv
package ismb_pkg;

    typedef enum logic [2:0] {
        ACT_BUS_READ  = 3'd0,
        ACT_BUS_WRITE = 3'd1,
        ACT_I2C_SETOFF = 3'd2,
        ACT_I2C_WRITE = 3'd3,
        ACT_I2C_READ  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    localparam logic [9:0] R_SADDR = 10'h00;
    localparam logic [9:0] R_EN_BIT = 10'h01;
    localparam logic [9:0] R_DEBOUNCE = 10'h02;
    localparam logic [9:0] R_CLKDLY = 10'h03;
    localparam logic [9:0] R_DATDLY = 10'h04;
    localparam logic [9:0] R_MB2BUS = 10'h10;
    localparam logic [9:0] R_MB2BUS_F = 10'h11;
    localparam logic [9:0] R_MB2I2C = 10'h12;
    localparam logic [9:0] R_MB2I2C_F = 10'h13;
    localparam logic [9:0] R_TB_PUSH = 10'h20;
    localparam logic [9:0] R_TB_POP = 10'h21;
    localparam logic [9:0] R_TB_FLUSH = 10'h22;
    localparam logic [9:0] R_TB_WLVL = 10'h23;
    localparam logic [9:0] R_TB_RLVL = 10'h24;
    localparam logic [9:0] R_TI_PUSH = 10'h30;
    localparam logic [9:0] R_TI_POP = 10'h31;
    localparam logic [9:0] R_TI_FLUSH = 10'h32;
    localparam logic [9:0] R_TI_WLVL = 10'h33;
    localparam logic [9:0] R_TI_RLVL = 10'h34;
    localparam logic [9:0] R_I2C_IRQ = 10'h40;
    localparam logic [9:0] R_I2C_EN = 10'h41;
    localparam logic [9:0] R_I2C_WSEL = 10'h42;
    localparam logic [9:0] R_I2C_RSEL = 10'h43;
    localparam logic [9:0] R_BUS_IRQ = 10'h50;
    localparam logic [9:0] R_BUS_EN = 10'h51;
    localparam logic [9:0] R_BUS_WSEL = 10'h52;
    localparam logic [9:0] R_BUS_RSEL = 10'h53;

endpackage

FILE: design/i2c_slave_mailbox_fifo_bridge_unit.sv
// Channel | Ports                                              | Direction
// access  | s_valid s_ready s_action s_reg_index s_write_data   | in
// result  | m_valid m_ready m_read_data m_i2c_side_irq          | out
//         | m_bus_side_irq m_slave_address m_bad_offset          |
// Each beat passes in order through the accept cycle, an execute cycle in
// which the captured access is decoded against the registered FIFO read data
// and the state and result register are updated, and an output state that
// holds the result until taken. The next beat is accepted in the cycle after the
// result is taken. Reset is synchronous, active low, and needs no clearing pass.
// A stalled result holds in the output register and keeps s_ready low.
module i2c_slave_mailbox_fifo_bridge_unit #(
    parameter int FIFO_DEPTH = 256,
    parameter int DEFAULT_SLAVE_ADDRESS = 90
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [9:0] s_reg_index,
    input  logic [7:0] s_write_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_i2c_side_irq,
    output logic       m_bus_side_irq,
    output logic [6:0] m_slave_address,
    output logic       m_bad_offset
);
    import ismb_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    state_t state_reg, state_next;

    // The captured access.
    logic [2:0] act_reg;
    logic [9:0] idx_reg;
    logic [7:0] wd_reg;

    // Control and configuration registers.
    logic [6:0] saddr_reg;
    logic       enable_reg;
    logic [7:0] debounce_reg, clkdly_reg, datdly_reg;
    logic [7:0] mb2bus_reg, mb2i2c_reg;
    logic       mb2bus_full_reg, mb2i2c_full_reg;
    logic [1:0] flush_reg;
    logic [7:0] i2c_off_reg;
    logic [2:0] i2c_en_reg, bus_en_reg;
    logic [7:0] i2c_wsel_reg, i2c_rsel_reg, bus_wsel_reg, bus_rsel_reg;

    // FIFO pointers; index 0 is the to-bus FIFO, index 1 the to-i2c FIFO.
    logic [AW-1:0] head_reg [2];
    logic [AW-1:0] tail_reg [2];
    logic [CW-1:0] cnt_reg [2];

    // Effective access, with the i2c offset standing in for the index.
    logic       is_bus, is_i2c_rd, is_i2c_wr, is_bus_rd, is_bus_wr;
    logic [9:0] eff_idx;

    always_comb begin
        is_bus_rd = (act_reg == ACT_BUS_READ);
        is_bus_wr = (act_reg == ACT_BUS_WRITE);
        is_i2c_wr = (act_reg == ACT_I2C_WRITE);
        is_i2c_rd = (act_reg == ACT_I2C_READ);
        is_bus = is_bus_rd || is_bus_wr;
        eff_idx = is_bus ? idx_reg : {2'b00, i2c_off_reg};
    end

    // Push and pop decode, valid during the execute cycle.
    logic push_tb, push_ti, pop_tb, pop_ti;
    always_comb begin
        push_tb = is_i2c_wr && (eff_idx == R_TB_PUSH) && (cnt_reg[0] != CW'(FIFO_DEPTH));
        push_ti = is_bus_wr && (eff_idx == R_TI_PUSH) && (cnt_reg[1] != CW'(FIFO_DEPTH));
        pop_tb = is_bus_rd && (eff_idx == R_TB_POP) && (cnt_reg[0] != '0);
        pop_ti = is_i2c_rd && (eff_idx == R_TI_POP) && (cnt_reg[1] != '0);
    end

    // Pointer increment with wrap at the depth.
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(FIFO_DEPTH - 1)) r = '0;
        else r = p + AW'(1);
        return r;
    endfunction

    // The memories are read from the head at all times; the head is stable from
    // accept through execute, so the registered data is current when it is used.
    logic [7:0] tb_rdata, ti_rdata;

    ismb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tb_ram (
        .aclk  (aclk),
        .we    (state_reg == ST_EXEC && push_tb),
        .waddr (tail_reg[0]),
        .wdata (wd_reg),
        .raddr (head_reg[0]),
        .rdata (tb_rdata)
    );

    ismb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_ti_ram (
        .aclk  (aclk),
        .we    (state_reg == ST_EXEC && push_ti),
        .waddr (tail_reg[1]),
        .wdata (wd_reg),
        .raddr (head_reg[1]),
        .rdata (ti_rdata)
    );

    // Level encoders for a count.
    function automatic logic [2:0] wr_level(input logic [CW-1:0] used);
        logic [CW:0] left;
        logic [2:0]  l;
        left = (CW+1)'(FIFO_DEPTH) - {1'b0, used};
        if (left >= 128) l = 3'd0;
        else if (left >= 64) l = 3'd1;
        else if (left >= 32) l = 3'd2;
        else if (left >= 8) l = 3'd3;
        else if (left >= 4) l = 3'd4;
        else if (left >= 2) l = 3'd5;
        else if (left >= 1) l = 3'd6;
        else l = 3'd7;
        return l;
    endfunction

    function automatic logic [2:0] rd_level(input logic [CW-1:0] used);
        logic [2:0] l;
        if (used >= 128) l = 3'd7;
        else if (used >= 64) l = 3'd6;
        else if (used >= 32) l = 3'd5;
        else if (used >= 8) l = 3'd4;
        else if (used >= 4) l = 3'd3;
        else if (used >= 2) l = 3'd2;
        else if (used >= 1) l = 3'd1;
        else l = 3'd0;
        return l;
    endfunction

    // Levels and interrupt words are derived from the stored state, so they
    // are current as soon as a beat has updated that state.
    logic [2:0] lvl_tb_w, lvl_tb_r, lvl_ti_w, lvl_ti_r;
    logic [2:0] i2c_word, bus_word;
    always_comb begin
        lvl_tb_w = wr_level(cnt_reg[0]);
        lvl_tb_r = rd_level(cnt_reg[0]);
        lvl_ti_w = wr_level(cnt_reg[1]);
        lvl_ti_r = rd_level(cnt_reg[1]);
        i2c_word = {i2c_en_reg[2] & i2c_wsel_reg[lvl_tb_w],
                    i2c_en_reg[1] & i2c_rsel_reg[lvl_tb_r],
                    i2c_en_reg[0] & mb2i2c_full_reg};
        bus_word = {bus_en_reg[2] & bus_wsel_reg[lvl_ti_w],
                    bus_en_reg[1] & bus_rsel_reg[lvl_ti_r],
                    bus_en_reg[0] & mb2bus_full_reg};
    end

    // Read data and bad offset for the access in execute.
    logic [7:0] rd_val;
    logic       common_hit, bad_val;
    always_comb begin
        common_hit = 1'b1;
        rd_val = '0;
        case (eff_idx)
            R_SADDR:    rd_val = {1'b0, saddr_reg};
            R_EN_BIT:   rd_val = {7'd0, enable_reg};
            R_DEBOUNCE: rd_val = debounce_reg;
            R_CLKDLY:   rd_val = clkdly_reg;
            R_DATDLY:   rd_val = datdly_reg;
            R_MB2BUS_F: rd_val = {7'd0, mb2bus_full_reg};
            R_MB2I2C_F: rd_val = {7'd0, mb2i2c_full_reg};
            R_TB_FLUSH: rd_val = {7'd0, flush_reg[0]};
            R_TB_WLVL:  rd_val = {5'd0, lvl_tb_w};
            R_TB_RLVL:  rd_val = {5'd0, lvl_tb_r};
            R_TI_FLUSH: rd_val = {7'd0, flush_reg[1]};
            R_TI_WLVL:  rd_val = {5'd0, lvl_ti_w};
            R_TI_RLVL:  rd_val = {5'd0, lvl_ti_r};
            R_I2C_IRQ:  rd_val = {5'd0, i2c_word};
            R_I2C_EN:   rd_val = {5'd0, i2c_en_reg};
            R_I2C_WSEL: rd_val = i2c_wsel_reg;
            R_I2C_RSEL: rd_val = i2c_rsel_reg;
            R_BUS_IRQ:  rd_val = {5'd0, bus_word};
            R_BUS_EN:   rd_val = {5'd0, bus_en_reg};
            R_BUS_WSEL: rd_val = bus_wsel_reg;
            R_BUS_RSEL: rd_val = bus_rsel_reg;
            default:    common_hit = 1'b0;
        endcase
        // Mailbox and pop ports override the common decode.
        if (eff_idx == R_MB2BUS || eff_idx == R_MB2I2C) begin
            rd_val = (eff_idx == R_MB2BUS) ? mb2bus_reg : mb2i2c_reg;
        end
        if (is_bus_rd && eff_idx == R_TB_POP) rd_val = pop_tb ? tb_rdata : 8'd0;
        if (is_i2c_rd && eff_idx == R_TI_POP) rd_val = pop_ti ? ti_rdata : 8'd0;
        if (!(is_bus_rd || is_i2c_rd)) rd_val = '0;
        if (is_i2c_rd && !(common_hit || eff_idx == R_MB2BUS || eff_idx == R_MB2I2C
                || eff_idx == R_TI_POP)) begin
            rd_val = '0;
        end
        if (is_bus_rd && !(common_hit || eff_idx == R_MB2BUS || eff_idx == R_MB2I2C
                || eff_idx == R_TB_POP)) begin
            rd_val = '0;
        end

        bad_val = 1'b0;
        if (is_bus_rd) begin
            bad_val = !(common_hit || eff_idx == R_MB2BUS || eff_idx == R_MB2I2C
                || eff_idx == R_TB_POP);
        end else if (is_bus_wr) begin
            bad_val = !(eff_idx == R_SADDR || eff_idx == R_EN_BIT
                || eff_idx == R_DEBOUNCE || eff_idx == R_CLKDLY || eff_idx == R_DATDLY
                || eff_idx == R_MB2I2C || eff_idx == R_TB_FLUSH || eff_idx == R_TI_PUSH
                || eff_idx == R_TI_FLUSH || eff_idx == R_BUS_EN || eff_idx == R_BUS_WSEL
                || eff_idx == R_BUS_RSEL);
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg <= s_action;
            idx_reg <= s_reg_index;
            wd_reg <= s_write_data;
        end
        if (state_reg == ST_EXEC) begin
            m_read_data <= rd_val;
            m_bad_offset <= bad_val;
        end
    end

    // Interrupts and address are shown from state, so they follow the update.
    assign m_i2c_side_irq = |i2c_word;
    assign m_bus_side_irq = |bus_word;
    assign m_slave_address = saddr_reg;

    logic wr_any, flush_tb_wr, flush_ti_wr;
    always_comb begin
        wr_any = is_bus_wr || is_i2c_wr;
        flush_tb_wr = wr_any && eff_idx == R_TB_FLUSH;
        flush_ti_wr = wr_any && eff_idx == R_TI_FLUSH;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saddr_reg <= 7'(DEFAULT_SLAVE_ADDRESS);
            enable_reg <= 1'b0;
            debounce_reg <= 8'd20;
            clkdly_reg <= 8'd20;
            datdly_reg <= 8'd8;
            mb2bus_reg <= '0;
            mb2i2c_reg <= '0;
            mb2bus_full_reg <= 1'b0;
            mb2i2c_full_reg <= 1'b0;
            flush_reg <= '0;
            i2c_off_reg <= '0;
            i2c_en_reg <= '0;
            bus_en_reg <= '0;
            i2c_wsel_reg <= '0;
            i2c_rsel_reg <= '0;
            bus_wsel_reg <= '0;
            bus_rsel_reg <= '0;
            for (int f = 0; f < 2; f++) begin
                head_reg[f] <= '0;
                tail_reg[f] <= '0;
                cnt_reg[f] <= '0;
            end
        end else if (state_reg == ST_EXEC) begin
            if (act_reg == ACT_I2C_SETOFF) i2c_off_reg <= idx_reg[7:0];
            if (is_bus_wr) begin
                case (eff_idx)
                    R_SADDR:    saddr_reg <= wd_reg[6:0];
                    R_EN_BIT:   enable_reg <= wd_reg[0];
                    R_DEBOUNCE: debounce_reg <= wd_reg;
                    R_CLKDLY:   clkdly_reg <= wd_reg;
                    R_DATDLY:   datdly_reg <= wd_reg;
                    R_MB2I2C: begin
                        mb2i2c_reg <= wd_reg;
                        mb2i2c_full_reg <= 1'b1;
                    end
                    R_BUS_EN:   bus_en_reg <= wd_reg[2:0];
                    R_BUS_WSEL: bus_wsel_reg <= wd_reg;
                    R_BUS_RSEL: bus_rsel_reg <= wd_reg;
                    default: ;
                endcase
            end
            if (is_i2c_wr) begin
                case (eff_idx)
                    R_MB2BUS: begin
                        mb2bus_reg <= wd_reg;
                        mb2bus_full_reg <= 1'b1;
                    end
                    R_I2C_EN:   i2c_en_reg <= wd_reg[2:0];
                    R_I2C_WSEL: i2c_wsel_reg <= wd_reg;
                    R_I2C_RSEL: i2c_rsel_reg <= wd_reg;
                    default: ;
                endcase
            end
            if (is_bus_rd && eff_idx == R_MB2BUS) mb2bus_full_reg <= 1'b0;
            if (is_i2c_rd && eff_idx == R_MB2I2C) mb2i2c_full_reg <= 1'b0;

            if (flush_tb_wr) flush_reg[0] <= wd_reg[0];
            if (flush_ti_wr) flush_reg[1] <= wd_reg[0];

            if (flush_tb_wr && wd_reg[0]) begin
                head_reg[0] <= '0;
                tail_reg[0] <= '0;
                cnt_reg[0] <= '0;
            end else if (push_tb) begin
                tail_reg[0] <= ptr_inc(tail_reg[0]);
                cnt_reg[0] <= cnt_reg[0] + CW'(1);
            end else if (pop_tb) begin
                head_reg[0] <= ptr_inc(head_reg[0]);
                cnt_reg[0] <= cnt_reg[0] - CW'(1);
            end

            if (flush_ti_wr && wd_reg[0]) begin
                head_reg[1] <= '0;
                tail_reg[1] <= '0;
                cnt_reg[1] <= '0;
            end else if (push_ti) begin
                tail_reg[1] <= ptr_inc(tail_reg[1]);
                cnt_reg[1] <= cnt_reg[1] + CW'(1);
            end else if (pop_ti) begin
                head_reg[1] <= ptr_inc(head_reg[1]);
                cnt_reg[1] <= cnt_reg[1] - CW'(1);
            end
        end
    end
endmodule

FILE: design/ismb_ram.sv
module ismb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/ismb_checker.sv
`include "i2c_slave_mailbox_fifo_bridge_unit_macros.svh"

module ismb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_bad_offset
);
    `ISMB_ASSERT_IMP(no_overlap, aclk, aresetn, m_valid, !s_ready)
    `ISMB_ASSERT_NXT(out_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_data))
    `ISMB_ASSERT_NXT(accept_no_out, aclk, aresetn, s_valid && s_ready, !m_valid && !s_ready)
    `ISMB_ASSERT_IMP(bad_reads_zero, aclk, aresetn, m_valid && m_bad_offset, m_read_data == 8'd0)
endmodule

bind i2c_slave_mailbox_fifo_bridge_unit ismb_checker u_ismb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_bad_offset (m_bad_offset)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the mailbox and FIFO bridge. A directed table of
// accesses runs first, then random traffic built mostly from well-formed
// sequences: offset set followed by i2c bytes, FIFO fills and drains, mailbox
// handoffs, and interrupt enable and select changes. Every accepted input
// beat is run through the predictor and the expected result is queued;
// every accepted output beat is compared field by field.
module testbench;
    import ismb_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_action = '0;
    logic [9:0] s_reg_index = '0;
    logic [7:0] s_write_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic       m_i2c_side_irq;
    logic       m_bus_side_irq;
    logic [6:0] m_slave_address;
    logic       m_bad_offset;

    i2c_slave_mailbox_fifo_bridge_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_reg_index(s_reg_index), .s_write_data(s_write_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data),
        .m_i2c_side_irq(m_i2c_side_irq), .m_bus_side_irq(m_bus_side_irq),
        .m_slave_address(m_slave_address), .m_bad_offset(m_bad_offset)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    localparam int DEPTH = 256;
    localparam logic [6:0] RESET_ADDR = 7'd90;

    typedef struct packed {
        logic [7:0] rdata;
        logic       i2c_irq;
        logic       bus_irq;
        logic [6:0] saddr;
        logic       bad;
    } bridge_result_t;

    // Mirror of the bridge's programmer-visible state. Index 0 of the FIFO
    // arrays is the to-bus FIFO, index 1 the to-i2c FIFO.
    logic [6:0] saddr_q;
    logic       enable_q;
    logic [7:0] debounce_q, clk_dly_q, dat_dly_q;
    logic [7:0] mb_bus_q, mb_i2c_q;
    logic       mb_bus_full, mb_i2c_full;
    logic [1:0] flush_q;
    logic [7:0] fifo_mem [2][DEPTH];
    int         fifo_head [2], fifo_tail [2], fifo_used [2];
    logic [2:0] wlvl [2], rlvl [2];
    logic [2:0] i2c_word, i2c_en, bus_word, bus_en;
    logic [7:0] i2c_wsel, i2c_rsel, bus_wsel, bus_rsel;
    logic [7:0] i2c_off;

    bridge_result_t expected_results [$];

    function automatic void clear_bridge_model();
        saddr_q = RESET_ADDR;
        enable_q = 1'b0;
        debounce_q = 8'd20;
        clk_dly_q = 8'd20;
        dat_dly_q = 8'd8;
        mb_bus_q = '0; mb_i2c_q = '0;
        mb_bus_full = 1'b0; mb_i2c_full = 1'b0;
        flush_q = '0;
        for (int f = 0; f < 2; f++) begin
            fifo_head[f] = 0; fifo_tail[f] = 0; fifo_used[f] = 0;
            wlvl[f] = '0; rlvl[f] = '0;
        end
        i2c_word = '0; i2c_en = '0; bus_word = '0; bus_en = '0;
        i2c_wsel = '0; i2c_rsel = '0; bus_wsel = '0; bus_rsel = '0;
        i2c_off = '0;
    endfunction

    // The i2c interrupt watches the to-bus FIFO and the to-i2c mailbox; the
    // bus interrupt watches the to-i2c FIFO and the to-bus mailbox.
    function automatic void refresh_irq_words();
        i2c_word = {i2c_en[2] & i2c_wsel[wlvl[0]], i2c_en[1] & i2c_rsel[rlvl[0]],
                    i2c_en[0] & mb_i2c_full};
        bus_word = {bus_en[2] & bus_wsel[wlvl[1]], bus_en[1] & bus_rsel[rlvl[1]],
                    bus_en[0] & mb_bus_full};
    endfunction

    function automatic void refresh_levels(int f);
        int used;
        int left;
        used = fifo_used[f];
        left = DEPTH - used;
        if (left >= 128) wlvl[f] = 3'd0;
        else if (left >= 64) wlvl[f] = 3'd1;
        else if (left >= 32) wlvl[f] = 3'd2;
        else if (left >= 8) wlvl[f] = 3'd3;
        else if (left >= 4) wlvl[f] = 3'd4;
        else if (left >= 2) wlvl[f] = 3'd5;
        else if (left >= 1) wlvl[f] = 3'd6;
        else wlvl[f] = 3'd7;
        if (used >= 128) rlvl[f] = 3'd7;
        else if (used >= 64) rlvl[f] = 3'd6;
        else if (used >= 32) rlvl[f] = 3'd5;
        else if (used >= 8) rlvl[f] = 3'd4;
        else if (used >= 4) rlvl[f] = 3'd3;
        else if (used >= 2) rlvl[f] = 3'd2;
        else if (used >= 1) rlvl[f] = 3'd1;
        else rlvl[f] = 3'd0;
        refresh_irq_words();
    endfunction

    function automatic void fifo_push(int f, logic [7:0] v);
        if (fifo_used[f] >= DEPTH) return;
        fifo_mem[f][fifo_tail[f]] = v;
        fifo_tail[f] = (fifo_tail[f] + 1) % DEPTH;
        fifo_used[f]++;
        refresh_levels(f);
    endfunction

    function automatic logic [7:0] fifo_pop(int f);
        logic [7:0] v;
        if (fifo_used[f] == 0) return 8'd0;
        v = fifo_mem[f][fifo_head[f]];
        fifo_head[f] = (fifo_head[f] + 1) % DEPTH;
        fifo_used[f]--;
        refresh_levels(f);
        return v;
    endfunction

    function automatic void flush_write(int f, logic [7:0] v);
        flush_q[f] = v[0];
        if (v[0]) begin
            fifo_head[f] = 0; fifo_tail[f] = 0; fifo_used[f] = 0;
            refresh_levels(f);
        end
    endfunction

    // Registers that both sides can read. Returns 0 when not decoded.
    function automatic bit shared_read(logic [9:0] idx, output logic [7:0] v);
        v = '0;
        case (idx)
            R_SADDR:    v = {1'b0, saddr_q};
            R_EN_BIT:   v = {7'd0, enable_q};
            R_DEBOUNCE: v = debounce_q;
            R_CLKDLY:   v = clk_dly_q;
            R_DATDLY:   v = dat_dly_q;
            R_MB2BUS_F: v = {7'd0, mb_bus_full};
            R_MB2I2C_F: v = {7'd0, mb_i2c_full};
            R_TB_FLUSH: v = {7'd0, flush_q[0]};
            R_TB_WLVL:  v = {5'd0, wlvl[0]};
            R_TB_RLVL:  v = {5'd0, rlvl[0]};
            R_TI_FLUSH: v = {7'd0, flush_q[1]};
            R_TI_WLVL:  v = {5'd0, wlvl[1]};
            R_TI_RLVL:  v = {5'd0, rlvl[1]};
            R_I2C_IRQ:  v = {5'd0, i2c_word};
            R_I2C_EN:   v = {5'd0, i2c_en};
            R_I2C_WSEL: v = i2c_wsel;
            R_I2C_RSEL: v = i2c_rsel;
            R_BUS_IRQ:  v = {5'd0, bus_word};
            R_BUS_EN:   v = {5'd0, bus_en};
            R_BUS_WSEL: v = bus_wsel;
            R_BUS_RSEL: v = bus_rsel;
            default:    return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic bridge_result_t bridge_access(logic [2:0] act, logic [9:0] idx,
                                                     logic [7:0] wd);
        bridge_result_t r;
        logic [7:0] v;
        r = '0;
        case (act)
            ACT_BUS_READ: begin
                if (idx == R_MB2BUS) begin
                    r.rdata = mb_bus_q;
                    mb_bus_full = 1'b0;
                    refresh_irq_words();
                end else if (idx == R_MB2I2C) begin
                    r.rdata = mb_i2c_q;
                end else if (idx == R_TB_POP) begin
                    r.rdata = fifo_pop(0);
                end else if (shared_read(idx, v)) begin
                    r.rdata = v;
                end else begin
                    r.bad = 1'b1;
                end
            end
            ACT_BUS_WRITE: begin
                case (idx)
                    R_SADDR:    saddr_q = wd[6:0];
                    R_EN_BIT:   enable_q = wd[0];
                    R_DEBOUNCE: debounce_q = wd;
                    R_CLKDLY:   clk_dly_q = wd;
                    R_DATDLY:   dat_dly_q = wd;
                    R_MB2I2C: begin
                        mb_i2c_q = wd;
                        mb_i2c_full = 1'b1;
                    end
                    R_TB_FLUSH: flush_write(0, wd);
                    R_TI_PUSH:  fifo_push(1, wd);
                    R_TI_FLUSH: flush_write(1, wd);
                    R_BUS_EN:   bus_en = wd[2:0];
                    R_BUS_WSEL: bus_wsel = wd;
                    R_BUS_RSEL: bus_rsel = wd;
                    default:    r.bad = 1'b1;
                endcase
                refresh_irq_words();
            end
            ACT_I2C_SETOFF: i2c_off = idx[7:0];
            ACT_I2C_WRITE: begin
                case ({2'b00, i2c_off})
                    R_MB2BUS: begin
                        mb_bus_q = wd;
                        mb_bus_full = 1'b1;
                    end
                    R_TB_PUSH:  fifo_push(0, wd);
                    R_TB_FLUSH: flush_write(0, wd);
                    R_TI_FLUSH: flush_write(1, wd);
                    R_I2C_EN:   i2c_en = wd[2:0];
                    R_I2C_WSEL: i2c_wsel = wd;
                    R_I2C_RSEL: i2c_rsel = wd;
                    default: ;
                endcase
                refresh_irq_words();
            end
            ACT_I2C_READ: begin
                if ({2'b00, i2c_off} == R_MB2BUS) begin
                    r.rdata = mb_bus_q;
                end else if ({2'b00, i2c_off} == R_MB2I2C) begin
                    r.rdata = mb_i2c_q;
                    mb_i2c_full = 1'b0;
                    refresh_irq_words();
                end else if ({2'b00, i2c_off} == R_TI_POP) begin
                    r.rdata = fifo_pop(1);
                end else if (shared_read({2'b00, i2c_off}, v)) begin
                    r.rdata = v;
                end
            end
            default: ;
        endcase
        r.i2c_irq = |i2c_word;
        r.bus_irq = |bus_word;
        r.saddr = saddr_q;
        return r;
    endfunction

    // Expected results are computed at the edge where the input beat is taken.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_results.push_back(bridge_access(s_action, s_reg_index, s_write_data));
    end

    int mismatch_count = 0;
    int failures = 0;

    always @(posedge aclk) begin
        bridge_result_t got;
        bridge_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_read_data, m_i2c_side_irq, m_bus_side_irq, m_slave_address,
                    m_bad_offset};
            if (expected_results.size() == 0) begin
                failures++;
                if (mismatch_count < 10) $display("unexpected result beat %p", got);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    failures++;
                    if (mismatch_count < 10)
                        $display("result mismatch: expected %p got %p", want, got);
                    mismatch_count++;
                end
            end
        end
    end

    // Idle percentages for the two sides; the receiver also has a hold-off
    // window used to fill up the bridge and stall its input.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one beat and waits for its acceptance. Valid stays high across
    // back-to-back beats because it is only lowered when an idle gap is chosen.
    task automatic send_beat(logic [2:0] act, logic [9:0] idx, logic [7:0] wd);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_reg_index <= idx;
        s_write_data <= wd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    typedef struct {
        logic [2:0] act;
        logic [9:0] idx;
        logic [7:0] wd;
        bit         check_data;
        logic [7:0] rdata;
    } directed_row_t;

    // Reads after reset, extremes of several fields, both mailboxes, both FIFOs
    // including the empty pop, the flush, and undecoded accesses.
    directed_row_t directed_rows [] = '{
        '{ACT_BUS_READ,  R_SADDR,    8'h00, 1, 8'd90},
        '{ACT_BUS_READ,  R_DEBOUNCE, 8'h00, 1, 8'd20},
        '{ACT_BUS_READ,  R_DATDLY,   8'h00, 1, 8'd8},
        '{ACT_BUS_READ,  R_TB_POP,   8'h00, 1, 8'd0},
        '{ACT_BUS_READ,  10'h3FF,    8'h00, 1, 8'd0},
        '{ACT_BUS_WRITE, 10'h3FF,    8'hFF, 0, 8'd0},
        '{ACT_BUS_WRITE, R_SADDR,    8'hFF, 0, 8'd0},
        '{ACT_BUS_WRITE, R_BUS_EN,   8'hFF, 0, 8'd0},
        '{ACT_BUS_WRITE, R_BUS_RSEL, 8'hFE, 0, 8'd0},
        '{ACT_BUS_WRITE, R_TI_PUSH,  8'hA5, 0, 8'd0},
        '{ACT_BUS_WRITE, R_MB2I2C,   8'h5A, 0, 8'd0},
        '{ACT_I2C_SETOFF, 10'h3FF,   8'h00, 0, 8'd0},
        '{ACT_I2C_READ,  10'h000,    8'h00, 1, 8'd0},
        '{ACT_I2C_SETOFF, R_MB2I2C,  8'h00, 0, 8'd0},
        '{ACT_I2C_READ,  10'h000,    8'h00, 1, 8'h5A},
        '{ACT_I2C_SETOFF, R_TI_POP,  8'h00, 0, 8'd0},
        '{ACT_I2C_READ,  10'h000,    8'h00, 1, 8'hA5},
        '{ACT_I2C_READ,  10'h000,    8'h00, 1, 8'd0},
        '{ACT_I2C_SETOFF, R_MB2BUS,  8'h00, 0, 8'd0},
        '{ACT_I2C_WRITE, 10'h000,    8'hFF, 0, 8'd0},
        '{ACT_BUS_READ,  R_MB2BUS,   8'h00, 1, 8'hFF},
        '{ACT_I2C_SETOFF, R_TB_PUSH, 8'h00, 0, 8'd0},
        '{ACT_I2C_WRITE, 10'h000,    8'h00, 0, 8'd0},
        '{ACT_BUS_WRITE, R_TB_FLUSH, 8'h01, 0, 8'd0},
        '{3'd7,          10'h3FF,    8'hFF, 0, 8'd0}
    };

    // Register indices that are decoded somewhere, so random accesses mostly
    // land on live registers.
    logic [9:0] live_regs [] = '{
        R_SADDR, R_EN_BIT, R_DEBOUNCE, R_CLKDLY, R_DATDLY, R_MB2BUS, R_MB2BUS_F,
        R_MB2I2C, R_MB2I2C_F, R_TB_PUSH, R_TB_POP, R_TB_FLUSH, R_TB_WLVL,
        R_TB_RLVL, R_TI_PUSH, R_TI_POP, R_TI_FLUSH, R_TI_WLVL, R_TI_RLVL,
        R_I2C_IRQ, R_I2C_EN, R_I2C_WSEL, R_I2C_RSEL, R_BUS_IRQ, R_BUS_EN,
        R_BUS_WSEL, R_BUS_RSEL
    };

    function automatic logic [9:0] pick_index();
        if ($urandom_range(9) < 8) return live_regs[$urandom_range(live_regs.size() - 1)];
        return 10'($urandom);
    endfunction

    // One random sequence. Most are well formed: an offset followed by a
    // burst of i2c bytes, a run of FIFO pushes or pops, or a handoff.
    task automatic random_sequence(output int beats);
        int n;
        beats = 0;
        case ($urandom_range(7))
            0: begin
                send_beat(ACT_I2C_SETOFF, pick_index(), 8'($urandom));
                n = $urandom_range(6, 1);
                repeat (n) send_beat($urandom_range(1) ? ACT_I2C_WRITE : ACT_I2C_READ,
                                     10'($urandom), 8'($urandom));
                beats = n + 1;
            end
            1: begin
                n = $urandom_range(40, 1);
                repeat (n) send_beat(ACT_BUS_WRITE, R_TI_PUSH, 8'($urandom));
                send_beat(ACT_I2C_SETOFF, R_TI_POP, 8'($urandom));
                repeat (n / 2 + 1) send_beat(ACT_I2C_READ, 10'($urandom), 8'($urandom));
                beats = n + n / 2 + 2;
            end
            2: begin
                send_beat(ACT_I2C_SETOFF, R_TB_PUSH, 8'($urandom));
                n = $urandom_range(40, 1);
                repeat (n) send_beat(ACT_I2C_WRITE, 10'($urandom), 8'($urandom));
                repeat (n / 2 + 1) send_beat(ACT_BUS_READ, R_TB_POP, 8'($urandom));
                beats = n + n / 2 + 2;
            end
            3: begin
                send_beat(ACT_BUS_WRITE, R_MB2I2C, 8'($urandom));
                send_beat(ACT_I2C_SETOFF, R_MB2I2C, 8'($urandom));
                send_beat(ACT_I2C_READ, 10'($urandom), 8'($urandom));
                send_beat(ACT_I2C_SETOFF, R_MB2BUS, 8'($urandom));
                send_beat(ACT_I2C_WRITE, 10'($urandom), 8'($urandom));
                send_beat(ACT_BUS_READ, R_MB2BUS, 8'($urandom));
                beats = 6;
            end
            4: begin
                send_beat(ACT_I2C_SETOFF, 10'($urandom_range(3, 1)) + R_I2C_IRQ,
                          8'($urandom));
                send_beat(ACT_I2C_WRITE, 10'($urandom), 8'($urandom));
                send_beat(ACT_BUS_WRITE, 10'($urandom_range(3, 1)) + R_BUS_IRQ,
                          8'($urandom));
                beats = 3;
            end
            5: begin
                send_beat(ACT_BUS_WRITE, $urandom_range(1) ? R_TB_FLUSH : R_TI_FLUSH,
                          8'($urandom));
                beats = 1;
            end
            default: begin
                send_beat(3'($urandom), pick_index(), 8'($urandom));
                beats = 1;
            end
        endcase
    endtask

    initial begin
        int sent;
        int beats;
        clear_bridge_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: the typed-in read data is checked on top of the
        // predictor, which keeps checking every field.
        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].act, directed_rows[i].idx, directed_rows[i].wd);
            if (directed_rows[i].check_data) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (expected_results.size() != 0) @(posedge aclk);
                if (m_read_data !== directed_rows[i].rdata) begin
                    failures++;
                    if (mismatch_count < 10)
                        $display("row %0d: read data expected %h got %h", i,
                                 directed_rows[i].rdata, m_read_data);
                    mismatch_count++;
                end
            end
        end

        // Fill the to-i2c FIFO past full while the receiver holds off, so the
        // bridge backs up and the dropped-push case is reached.
        hold_off_cycles = 300;
        repeat (DEPTH + 4) send_beat(ACT_BUS_WRITE, R_TI_PUSH, 8'($urandom));
        send_beat(ACT_BUS_READ, R_TI_WLVL, 8'd0);

        // Random traffic across four idling phases.
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            while (sent < (phase + 1) * 1250 / 4) begin
                random_sequence(beats);
                sent += beats;
            end
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule
